// File: hw/rtl/like_pattern_to_regex_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the LIKE pattern to regex converter
// Concurrent assertion wrappers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef LIKE_PATTERN_TO_REGEX_CORE_ASSERT_SVH
`define LIKE_PATTERN_TO_REGEX_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Checked only while reset is released.
`define LPR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
// Checked at every edge, reset cycles included.
`define LPR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");
`else
`define LPR_ASSERT(lbl, clk, rst_n, prop)
`define LPR_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: hw/rtl/lpr_pkg.sv
// ----------------------------------------------------------------------------
// LIKE pattern to regex package
// Transaction types, character codes and the metacharacter test.
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int unsigned MaxResults = 4;

    localparam logic [7:0] C_PERCENT   = 8'h25;
    localparam logic [7:0] C_UNDERBAR  = 8'h5F;
    localparam logic [7:0] C_CARET     = 8'h5E;
    localparam logic [7:0] C_DOLLAR    = 8'h24;
    localparam logic [7:0] C_DOT       = 8'h2E;
    localparam logic [7:0] C_STAR      = 8'h2A;
    localparam logic [7:0] C_BACKSLASH = 8'h5C;
    localparam logic [7:0] C_PLUS      = 8'h2B;
    localparam logic [7:0] C_QUESTION  = 8'h3F;
    localparam logic [7:0] C_LBRACKET  = 8'h5B;
    localparam logic [7:0] C_RBRACKET  = 8'h5D;
    localparam logic [7:0] C_LPAREN    = 8'h28;
    localparam logic [7:0] C_RPAREN    = 8'h29;
    localparam logic [7:0] C_LBRACE    = 8'h7B;
    localparam logic [7:0] C_RBRACE    = 8'h7D;
    localparam logic [7:0] C_PIPE      = 8'h7C;

    typedef struct packed {
        logic [7:0] pattern_byte;
        logic       has_byte;
        logic       is_final;
    } t_in;

    typedef struct packed {
        logic [7:0] regex_byte;
        logic       regex_end;
    } t_out;

    // True for bytes that need a backslash to match literally.
    function automatic logic is_meta(input logic [7:0] c);
        logic res;
        res = (c == C_DOT)      || (c == C_PLUS)     || (c == C_STAR)     ||
              (c == C_QUESTION) || (c == C_LBRACKET) || (c == C_RBRACKET) ||
              (c == C_LPAREN)   || (c == C_RPAREN)   || (c == C_LBRACE)   ||
              (c == C_RBRACE)   || (c == C_CARET)    || (c == C_DOLLAR)   ||
              (c == C_PIPE)     || (c == C_BACKSLASH);
        return res;
    endfunction

endpackage

// File: hw/rtl/like_pattern_to_regex_core.sv
// ----------------------------------------------------------------------------
// LIKE pattern to regex core
// Streams an SQL LIKE pattern in and an anchored regular expression out.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one pattern byte per transaction, with
// has_byte marking a real byte and is_final marking the last transaction of
// a pattern. The output channel carries one regex byte per transaction;
// regex_end is set on the closing '$'. Each input transaction yields zero to
// four output transactions, computed in one pass and held as a group.
// The results of a transaction pass through the group register and then the
// output buffer before they are offered. Throughput: one input transaction
// per cycle while each yields at most one byte and the receiver keeps up,
// because the group register hands its bytes to the output buffer in the
// same cycle that it takes the next transaction. A larger group holds the
// input while the output buffer drains it, at most one byte per cycle.
// Reset (synchronous, active low) empties both buffers and starts a new
// pattern: the next transaction that has a byte or is final emits '^' first.
// When the receiver stalls, the output byte holds; the prepared group waits
// in its register and the input stops accepting until the group moves on.
// ----------------------------------------------------------------------------
`include "like_pattern_to_regex_core_assert.svh"

module like_pattern_to_regex_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lpr_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output lpr_pkg::t_out o_out_data
);

    // Pattern state: anchor still owed, and a backslash awaiting its operand.
    logic r_at_start;
    logic r_esc;
    logic n_at_start;
    logic n_esc;

    // Group register: the results of the last accepted transaction that had any.
    lpr_pkg::t_out r_grp [lpr_pkg::MaxResults];
    logic [2:0]    r_grp_cnt;
    logic          r_grp_valid;
    lpr_pkg::t_out n_grp [lpr_pkg::MaxResults];
    logic [2:0]    n_grp_cnt;

    // Output buffer: shifts down one entry per delivered transaction.
    lpr_pkg::t_out r_out [lpr_pkg::MaxResults];
    logic [2:0]    r_out_cnt;

    logic       in_acc;
    logic       take;
    logic       out_free;
    logic       move;
    logic       active;
    logic       anchor;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [1:0] b_cnt;

    assign in_acc   = i_in_valid && o_in_ready;
    assign take     = o_out_valid && i_out_ready;
    assign out_free = (r_out_cnt == 3'd0) || (take && (r_out_cnt == 3'd1));
    assign move     = r_grp_valid && out_free;

    // The group register can take a new transaction when it is empty or when
    // its current group moves to the output buffer in this cycle.
    assign o_in_ready  = !r_grp_valid || out_free;
    assign o_out_valid = (r_out_cnt != 3'd0);
    assign o_out_data  = r_out[0];

    // Body of the translation: up to two bytes for the pattern byte itself.
    always_comb begin
        logic [7:0] c;
        c          = i_in_data.pattern_byte;
        active     = i_in_data.has_byte || i_in_data.is_final;
        anchor     = active && r_at_start;
        b0         = c;
        b1         = c;
        b_cnt      = 2'd0;
        n_esc      = r_esc;
        n_at_start = r_at_start;
        if (active) begin
            n_at_start = 1'b0;
            if (i_in_data.has_byte) begin
                if (r_esc) begin
                    // Escaped byte: literal, even for the wildcards.
                    n_esc = 1'b0;
                    if (lpr_pkg::is_meta(c)) begin
                        b0    = lpr_pkg::C_BACKSLASH;
                        b_cnt = 2'd2;
                    end else begin
                        b_cnt = 2'd1;
                    end
                end else if (c == lpr_pkg::C_PERCENT) begin
                    b0    = lpr_pkg::C_DOT;
                    b1    = lpr_pkg::C_STAR;
                    b_cnt = 2'd2;
                end else if (c == lpr_pkg::C_UNDERBAR) begin
                    b0    = lpr_pkg::C_DOT;
                    b_cnt = 2'd1;
                end else if (c == lpr_pkg::C_BACKSLASH) begin
                    if (i_in_data.is_final) begin
                        // Lone trailing backslash stands for itself.
                        b0    = lpr_pkg::C_BACKSLASH;
                        b_cnt = 2'd2;
                    end else begin
                        n_esc = 1'b1;
                    end
                end else if (lpr_pkg::is_meta(c)) begin
                    b0    = lpr_pkg::C_BACKSLASH;
                    b_cnt = 2'd2;
                end else begin
                    b_cnt = 2'd1;
                end
            end else if (r_esc) begin
                // Pending escape closed by an empty final transaction.
                n_esc = 1'b0;
                b0    = lpr_pkg::C_BACKSLASH;
                b1    = lpr_pkg::C_BACKSLASH;
                b_cnt = 2'd2;
            end
            if (i_in_data.is_final) begin
                n_at_start = 1'b1;
                n_esc      = 1'b0;
            end
        end
    end

    // Pack anchor, body and closing '$' into consecutive slots.
    always_comb begin
        logic [2:0] idx;
        idx = 3'd0;
        for (int k = 0; k < lpr_pkg::MaxResults; k++) begin
            n_grp[k] = '{regex_byte: 8'h00, regex_end: 1'b0};
        end
        if (anchor) begin
            n_grp[idx[1:0]] = '{regex_byte: lpr_pkg::C_CARET, regex_end: 1'b0};
            idx = idx + 3'd1;
        end
        if (b_cnt != 2'd0) begin
            n_grp[idx[1:0]] = '{regex_byte: b0, regex_end: 1'b0};
            idx = idx + 3'd1;
        end
        if (b_cnt == 2'd2) begin
            n_grp[idx[1:0]] = '{regex_byte: b1, regex_end: 1'b0};
            idx = idx + 3'd1;
        end
        if (active && i_in_data.is_final) begin
            n_grp[idx[1:0]] = '{regex_byte: lpr_pkg::C_DOLLAR, regex_end: 1'b1};
            idx = idx + 3'd1;
        end
        n_grp_cnt = idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start  <= 1'b1;
            r_esc       <= 1'b0;
            r_grp_valid <= 1'b0;
            r_grp_cnt   <= 3'd0;
            r_out_cnt   <= 3'd0;
        end else begin
            if (in_acc) begin
                r_at_start <= n_at_start;
                r_esc      <= n_esc;
            end

            // A transaction with no results only updates the pattern state.
            if (in_acc && (n_grp_cnt != 3'd0)) begin
                r_grp       <= n_grp;
                r_grp_cnt   <= n_grp_cnt;
                r_grp_valid <= 1'b1;
            end else if (move) begin
                r_grp_valid <= 1'b0;
            end

            if (move) begin
                r_out     <= r_grp;
                r_out_cnt <= r_grp_cnt;
            end else if (take) begin
                for (int k = 0; k < lpr_pkg::MaxResults - 1; k++) begin
                    r_out[k] <= r_out[k + 1];
                end
                r_out_cnt <= r_out_cnt - 3'd1;
            end
        end
    end

    `LPR_ASSERT(a_grp_nonempty, i_clk, i_rst_n, r_grp_valid |-> (r_grp_cnt != 3'd0))
    `LPR_ASSERT(a_end_is_dollar, i_clk, i_rst_n,
        (o_out_valid && o_out_data.regex_end) |->
            (o_out_data.regex_byte == lpr_pkg::C_DOLLAR))
    `LPR_ASSERT(a_end_is_last, i_clk, i_rst_n,
        (o_out_valid && o_out_data.regex_end) |-> (r_out_cnt == 3'd1))
    `LPR_ASSERT(a_esc_after_anchor, i_clk, i_rst_n, r_esc |-> !r_at_start)
    `LPR_ASSERT_ALWAYS(a_reset_state, i_clk,
        !i_rst_n |=> (r_at_start && !r_esc && !o_out_valid && o_in_ready))

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIKE pattern to regex core testbench
// Sends LIKE patterns one byte per transaction with random gaps on both
// channels and checks every regex byte against an in-bench prediction.
// ----------------------------------------------------------------------------

module testbench;

    // ------------------------------------------------------------------------
    // Clock, reset and the signals that drive the core.
    // ------------------------------------------------------------------------
    logic          i_clk   = 1'b0;
    logic          rst_n   = 1'b0;
    logic          in_valid = 1'b0;
    lpr_pkg::t_in  in_data  = '0;
    logic          out_ready = 1'b0;
    logic          in_ready;
    logic          out_valid;
    lpr_pkg::t_out out_data;

    like_pattern_to_regex_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Shared state of the testbench.
    // When no_idle is set, neither the sender nor the receiver inserts any
    // wait cycles, so the core is run at its full rate.
    // ------------------------------------------------------------------------
    bit            no_idle = 1'b0;
    int            error_count = 0;
    int            stall_left = 0;
    int            bytes_sent = 0;
    lpr_pkg::t_out regex_expected[$];

    // Predicted converter state: the '^' anchor still to be written, and a
    // backslash that waits for the byte it escapes.
    bit anchor_due   = 1'b1;
    bit escape_armed = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Prediction of the regex bytes caused by one accepted transaction.
    // ------------------------------------------------------------------------
    function automatic bit is_regex_meta(input logic [7:0] c);
        case (c)
            lpr_pkg::C_DOT, lpr_pkg::C_PLUS, lpr_pkg::C_STAR, lpr_pkg::C_QUESTION,
            lpr_pkg::C_LBRACKET, lpr_pkg::C_RBRACKET, lpr_pkg::C_LPAREN,
            lpr_pkg::C_RPAREN, lpr_pkg::C_LBRACE, lpr_pkg::C_RBRACE,
            lpr_pkg::C_CARET, lpr_pkg::C_DOLLAR, lpr_pkg::C_PIPE,
            lpr_pkg::C_BACKSLASH: return 1'b1;
            default:              return 1'b0;
        endcase
    endfunction

    task automatic emit_regex(input logic [7:0] b, input logic is_end);
        lpr_pkg::t_out r;
        r.regex_byte = b;
        r.regex_end  = is_end;
        regex_expected.push_back(r);
    endtask

    // Literal text: metacharacters need a backslash in front of them.
    task automatic emit_literal(input logic [7:0] c);
        if (is_regex_meta(c)) begin
            emit_regex(lpr_pkg::C_BACKSLASH, 1'b0);
        end
        emit_regex(c, 1'b0);
    endtask

    task automatic predict_regex(input lpr_pkg::t_in item);
        // A transaction with no byte that does not end the pattern is ignored
        // completely, a pending escape included.
        if (!item.has_byte && !item.is_final) begin
            return;
        end
        if (anchor_due) begin
            emit_regex(lpr_pkg::C_CARET, 1'b0);
            anchor_due = 1'b0;
        end
        if (item.has_byte) begin
            if (escape_armed) begin
                // The escaped byte is literal, wildcards included.
                escape_armed = 1'b0;
                emit_literal(item.pattern_byte);
            end else if (item.pattern_byte == lpr_pkg::C_PERCENT) begin
                emit_regex(lpr_pkg::C_DOT, 1'b0);
                emit_regex(lpr_pkg::C_STAR, 1'b0);
            end else if (item.pattern_byte == lpr_pkg::C_UNDERBAR) begin
                emit_regex(lpr_pkg::C_DOT, 1'b0);
            end else if (item.pattern_byte == lpr_pkg::C_BACKSLASH) begin
                // A backslash on the last transaction has nothing to escape,
                // so it stands for itself.
                if (item.is_final) begin
                    emit_literal(lpr_pkg::C_BACKSLASH);
                end else begin
                    escape_armed = 1'b1;
                end
            end else begin
                emit_literal(item.pattern_byte);
            end
        end else if (escape_armed) begin
            // A pending escape closed by an empty final transaction.
            escape_armed = 1'b0;
            emit_literal(lpr_pkg::C_BACKSLASH);
        end
        if (item.is_final) begin
            emit_regex(lpr_pkg::C_DOLLAR, 1'b1);
            anchor_due   = 1'b1;
            escape_armed = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender: one input transaction per call. Inputs change at the falling
    // edge; the handshake is sampled at the rising edge. Valid is only
    // lowered when a gap is drawn, so it is never dropped and raised again
    // within one time step.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [7:0] b, input logic has, input logic last);
        int           gap;
        lpr_pkg::t_in item;
        item.pattern_byte = b;
        item.has_byte     = has;
        item.is_final     = last;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge i_clk);
        while (!in_ready) begin
            @(posedge i_clk);
        end
        predict_regex(item);
        if (has || last) begin
            bytes_sent++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: ready is driven at the falling edge. After each accepted
    // output transaction a new stall length is drawn.
    // ------------------------------------------------------------------------
    initial begin
        @(posedge rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Checker: every accepted output transaction is compared with the oldest
    // predicted regex byte.
    always @(posedge i_clk) begin
        lpr_pkg::t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (regex_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected regex byte 8'h%02h end=%b",
                                          out_data.regex_byte, out_data.regex_end));
            end else begin
                want = regex_expected.pop_front();
                if (out_data.regex_byte !== want.regex_byte) begin
                    report_mismatch($sformatf("regex_byte 8'h%02h, predicted 8'h%02h",
                                              out_data.regex_byte, want.regex_byte));
                end
                if (out_data.regex_end !== want.regex_end) begin
                    report_mismatch($sformatf("regex_end %b, predicted %b on byte 8'h%02h",
                                              out_data.regex_end, want.regex_end,
                                              want.regex_byte));
                end
            end
            stall_left = no_idle ? 0 : $urandom_range(0, 9);
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------------

    // Empty patterns give "^$", right after reset and after an ignored
    // transaction alike.
    task automatic test_empty_pattern();
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'hA5, 1'b0, 1'b1);
    endtask

    // Wildcards and the byte extremes in one pattern.
    task automatic test_wildcards();
        send_item(lpr_pkg::C_PERCENT, 1'b1, 1'b0);
        send_item(lpr_pkg::C_UNDERBAR, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
    endtask

    // Escaped wildcards and metacharacters, an ignored transaction between
    // the backslash and its operand, and both forms of a lone trailing
    // backslash.
    task automatic test_escapes();
        send_item(lpr_pkg::C_BACKSLASH, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(lpr_pkg::C_PERCENT, 1'b1, 1'b0);
        send_item(lpr_pkg::C_BACKSLASH, 1'b1, 1'b0);
        send_item(lpr_pkg::C_UNDERBAR, 1'b1, 1'b0);
        send_item(lpr_pkg::C_BACKSLASH, 1'b1, 1'b0);
        send_item(lpr_pkg::C_DOT, 1'b1, 1'b0);
        send_item(lpr_pkg::C_BACKSLASH, 1'b1, 1'b1);
        send_item(lpr_pkg::C_BACKSLASH, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
    endtask

    // Every metacharacter but the backslash as plain literal text.
    task automatic test_metacharacters();
        send_item(lpr_pkg::C_PLUS, 1'b1, 1'b0);
        send_item(lpr_pkg::C_QUESTION, 1'b1, 1'b0);
        send_item(lpr_pkg::C_LBRACKET, 1'b1, 1'b0);
        send_item(lpr_pkg::C_RBRACKET, 1'b1, 1'b0);
        send_item(lpr_pkg::C_LPAREN, 1'b1, 1'b0);
        send_item(lpr_pkg::C_RPAREN, 1'b1, 1'b0);
        send_item(lpr_pkg::C_LBRACE, 1'b1, 1'b0);
        send_item(lpr_pkg::C_RBRACE, 1'b1, 1'b0);
        send_item(lpr_pkg::C_CARET, 1'b1, 1'b0);
        send_item(lpr_pkg::C_DOLLAR, 1'b1, 1'b0);
        send_item(lpr_pkg::C_PIPE, 1'b1, 1'b0);
        send_item(lpr_pkg::C_STAR, 1'b1, 1'b0);
        send_item(lpr_pkg::C_DOT, 1'b1, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Random tests.
    // ------------------------------------------------------------------------
    function automatic logic [7:0] pick_pattern_byte();
        case ($urandom_range(0, 9))
            0, 1: return lpr_pkg::C_PERCENT;
            2:    return lpr_pkg::C_UNDERBAR;
            3, 4: return lpr_pkg::C_BACKSLASH;
            5, 6: begin
                case ($urandom_range(0, 13))
                    0:  return lpr_pkg::C_DOT;
                    1:  return lpr_pkg::C_PLUS;
                    2:  return lpr_pkg::C_STAR;
                    3:  return lpr_pkg::C_QUESTION;
                    4:  return lpr_pkg::C_LBRACKET;
                    5:  return lpr_pkg::C_RBRACKET;
                    6:  return lpr_pkg::C_LPAREN;
                    7:  return lpr_pkg::C_RPAREN;
                    8:  return lpr_pkg::C_LBRACE;
                    9:  return lpr_pkg::C_RBRACE;
                    10: return lpr_pkg::C_CARET;
                    11: return lpr_pkg::C_DOLLAR;
                    12: return lpr_pkg::C_PIPE;
                    default: return lpr_pkg::C_BACKSLASH;
                endcase
            end
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Well-formed patterns of random content, now and then with ignored
    // transactions mixed in and sometimes closed by an empty final one.
    task automatic test_random_patterns(input int count);
        int target;
        int len;
        int k;
        target = bytes_sent + count;
        while (bytes_sent < target) begin
            len = $urandom_range(0, 6);
            for (k = 0; k <= len; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                end
                if (k == len) begin
                    send_item(pick_pattern_byte(), ($urandom_range(0, 3) != 0), 1'b1);
                end else begin
                    send_item(pick_pattern_byte(), 1'b1, 1'b0);
                end
            end
        end
    endtask

    // Unstructured transactions: every field drawn at random.
    task automatic test_random_noise(input int count);
        int target;
        target = bytes_sent + count;
        while (bytes_sent < target) begin
            send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      ($urandom_range(0, 3) == 0));
        end
        send_item(pick_pattern_byte(), 1'b1, 1'b1);
    endtask

    // Lets the core finish all predicted output, then keeps watching so that
    // any spurious byte still shows up.
    task automatic drain_results();
        int waited;
        waited = 0;
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (regex_expected.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (regex_expected.size() != 0) begin
            report_mismatch($sformatf("%0d predicted regex bytes never arrived",
                                      regex_expected.size()));
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        test_empty_pattern();
        test_wildcards();
        test_escapes();
        test_metacharacters();

        test_random_patterns(30);
        // Full-rate stretch: no gaps on either channel.
        no_idle = 1'b1;
        test_random_patterns(20);
        no_idle = 1'b0;
        test_random_noise(15);

        drain_results();
        if (error_count == 0) begin
            $display("PASS like_pattern_to_regex_core");
        end else begin
            $display("FAIL like_pattern_to_regex_core");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #400000;
        $display("FAIL like_pattern_to_regex_core");
        $finish;
    end

endmodule
